/* hdl/wct_pkg.sv */
// ----------------------------------------------------------------------------
// wct_pkg
// Shared types, codes and encoding functions for the watchpoint comparator
// slot table.
// ----------------------------------------------------------------------------
package wct_pkg;

   // controller states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH
   } state_type;

   // request codes
   localparam logic [1:0] REQ_INSERT = 2'd0;
   localparam logic [1:0] REQ_REMOVE = 2'd1;
   localparam logic [1:0] REQ_HIT    = 2'd2;

   // watch kinds
   localparam logic [1:0] KIND_WRITE  = 2'd0;
   localparam logic [1:0] KIND_READ   = 2'd1;
   localparam logic [1:0] KIND_ACCESS = 2'd2;

   // register indexes
   localparam logic [1:0] CSR_ACTIVE_SLOTS = 2'd0;
   localparam logic [1:0] CSR_CORE_PROFILE = 2'd1;

   // core profiles
   localparam logic [1:0] PROFILE_BASE = 2'd0;
   localparam logic [1:0] PROFILE_V8   = 2'd2;

   localparam int unsigned SIZE_SHIFT = 10;
   localparam logic [31:0] V1_SIZE_HALF = 32'(1) << SIZE_SHIFT;
   localparam logic [31:0] V1_SIZE_WORD = 32'(2) << SIZE_SHIFT;
   localparam logic [31:0] V2_DEBUG_EVENT = 32'h0000_0010;

   localparam logic [31:0] V1_FUNC_READ   = 32'd5;
   localparam logic [31:0] V1_FUNC_WRITE  = 32'd6;
   localparam logic [31:0] V1_FUNC_ACCESS = 32'd7;
   localparam logic [31:0] V2_MATCH_ACCESS = 32'd4;
   localparam logic [31:0] V2_MATCH_WRITE  = 32'd5;
   localparam logic [31:0] V2_MATCH_READ   = 32'd6;

   typedef struct packed {
      logic load;
      logic scan;
      logic finish;
   } dp_cmd_type;

   typedef struct packed {
      logic n_zero;
      logic scan_last;
   } dp_status_type;

   function automatic logic [31:0] func_v1(input logic [1:0] kind, input logic [31:0] len,
                                           input logic [1:0] profile);
      logic [31:0] size;
      logic [31:0] res;
      size = '0;
      if (profile != PROFILE_BASE) begin
         if (len <= 32'd1) size = '0;
         else if (len == 32'd2) size = V1_SIZE_HALF;
         else size = V1_SIZE_WORD;
      end
      case (kind)
         KIND_WRITE:  res = V1_FUNC_WRITE | size;
         KIND_READ:   res = V1_FUNC_READ | size;
         KIND_ACCESS: res = V1_FUNC_ACCESS | size;
         default:     res = '0;
      endcase
      return res;
   endfunction

   function automatic logic [31:0] func_v2(input logic [1:0] kind, input logic [31:0] len);
      logic [31:0] match;
      logic [31:0] size;
      logic        bad;
      bad = 1'b0;
      case (kind)
         KIND_WRITE:  match = V2_MATCH_WRITE;
         KIND_READ:   match = V2_MATCH_READ;
         KIND_ACCESS: match = V2_MATCH_ACCESS;
         default: begin
            match = '0;
            bad = 1'b1;
         end
      endcase
      // zero length encodes as one byte, whose size field is zero anyway
      size = {len[22:1], 10'd0};
      return bad ? 32'd0 : (V2_DEBUG_EVENT | match | size);
   endfunction

   // log2 of a one-hot word
   function automatic logic [4:0] log2_onehot(input logic [31:0] v);
      logic [4:0] res;
      res = '0;
      for (int b = 0; b < 32; b++) begin
         if (v[b]) res = res | 5'(b);
      end
      return res;
   endfunction

endpackage

/* hdl/wct_ctrl.sv */
// ----------------------------------------------------------------------------
// wct_ctrl
// Request sequencer: loads a transaction, steps the slot scan and triggers the
// result and table update.
// ----------------------------------------------------------------------------
module wct_ctrl import wct_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  dp_status_type status,
   output dp_cmd_type    cmd,
   output logic          busy
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = status.n_zero ? ST_FINISH : ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
            if (status.scan_last) state_in = ST_FINISH;
         end
         ST_FINISH: begin
            cmd.finish = 1'b1;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

/* hdl/wct_datapath.sv */
// ----------------------------------------------------------------------------
// wct_datapath
// Slot table, per-slot scan logic, function word encoding and result
// registers.
// ----------------------------------------------------------------------------
module wct_datapath import wct_pkg::*; #(
   parameter int MAX_SLOTS = 4
) (
   input  logic          clock,
   input  logic          reset,
   input  dp_cmd_type    cmd,
   output dp_status_type status,
   input  logic [2:0]    n_slots,
   input  logic [1:0]    profile,
   input  logic [1:0]    req_type,
   input  logic [1:0]    req_watch_kind,
   input  logic [31:0]   req_watch_addr,
   input  logic [31:0]   req_watch_len,
   input  logic          req_trap_flag,
   input  logic [3:0]    req_matched_bits,
   output logic          rsp_strobe,
   output logic          rsp_ok,
   output logic          rsp_write_enable,
   output logic          rsp_write_mask_enable,
   output logic [1:0]    rsp_target_slot,
   output logic [31:0]   rsp_comparator_word,
   output logic [4:0]    rsp_mask_word,
   output logic [31:0]   rsp_function_word,
   output logic [1:0]    rsp_hit_kind,
   output logic [31:0]   rsp_hit_addr,
   output logic          rsp_clear_trap
);

   localparam int SW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;

   // slot table
   logic        used_ff [MAX_SLOTS];
   logic [31:0] slot_addr_ff [MAX_SLOTS];
   logic [31:0] slot_len_ff [MAX_SLOTS];
   logic [1:0]  slot_kind_ff [MAX_SLOTS];

   // latched transaction
   logic [1:0]  type_ff;
   logic [1:0]  kind_ff;
   logic [31:0] addr_ff;
   logic [31:0] len_ff;
   logic        trap_ff;
   logic [3:0]  matched_ff;

   // scan state
   logic [SW-1:0] idx_ff;
   logic          found_match_ff;
   logic [SW-1:0] match_idx_ff;
   logic          found_free_ff;
   logic [SW-1:0] free_idx_ff;
   logic          found_hit_ff;
   logic [1:0]    hit_kind_ff;
   logic [31:0]   hit_addr_ff;

   // result registers
   logic        strobe_ff;
   logic        ok_ff, ok_in;
   logic        we_ff, we_in;
   logic        wme_ff, wme_in;
   logic [1:0]  tslot_ff, tslot_in;
   logic [31:0] comp_ff, comp_in;
   logic [4:0]  mask_ff, mask_in;
   logic [31:0] func_ff, func_in;
   logic [1:0]  hkind_ff, hkind_in;
   logic [31:0] haddr_ff, haddr_in;
   logic        clr_ff, clr_in;

   logic        slot_match;
   logic        slot_free;
   logic        slot_hit;
   logic [3:0]  matched_shift;

   logic        is_v2;
   logic        len_pow2;
   logic [31:0] len_dec;
   logic [31:0] func_sel;
   logic        ins_go;
   logic        rem_go;
   logic [SW-1:0] tslot_idx;
   logic [31:0] tslot_wide;

   assign status.n_zero    = (n_slots == 3'd0);
   assign status.scan_last = ((32'(idx_ff) + 32'd1) == 32'(n_slots));

   // per-slot evaluation at the scan index
   assign slot_match = used_ff[idx_ff] && (slot_addr_ff[idx_ff] == addr_ff) &&
                       (slot_len_ff[idx_ff] == len_ff) && (slot_kind_ff[idx_ff] == kind_ff);
   assign slot_free  = !used_ff[idx_ff];
   // slots past the fourth have no matched flag
   assign matched_shift = matched_ff >> idx_ff;
   assign slot_hit   = matched_shift[0] && used_ff[idx_ff];

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         type_ff    <= req_type;
         kind_ff    <= req_watch_kind;
         addr_ff    <= req_watch_addr;
         len_ff     <= req_watch_len;
         trap_ff    <= req_trap_flag;
         matched_ff <= req_matched_bits;
         idx_ff         <= '0;
         found_match_ff <= 1'b0;
         found_free_ff  <= 1'b0;
         found_hit_ff   <= 1'b0;
      end else if (cmd.scan) begin
         idx_ff <= idx_ff + SW'(1);
         if (slot_match && !found_match_ff) begin
            found_match_ff <= 1'b1;
            match_idx_ff   <= idx_ff;
         end
         if (slot_free && !found_free_ff) begin
            found_free_ff <= 1'b1;
            free_idx_ff   <= idx_ff;
         end
         if (slot_hit && !found_hit_ff) begin
            found_hit_ff <= 1'b1;
            hit_kind_ff  <= slot_kind_ff[idx_ff];
            hit_addr_ff  <= slot_addr_ff[idx_ff];
         end
      end
   end

   // result decode
   assign is_v2    = (profile == PROFILE_V8);
   assign len_dec  = len_ff - 32'd1;
   assign len_pow2 = (len_ff != 32'd0) && ((len_ff & len_dec) == 32'd0);

   always_comb begin
      if (is_v2) func_sel = func_v2(kind_ff, len_ff);
      else if (len_pow2) func_sel = func_v1(kind_ff, len_ff, profile);
      else func_sel = '0;
   end

   assign ins_go = (type_ff == REQ_INSERT) && !found_match_ff && found_free_ff &&
                   (func_sel != 32'd0);
   assign rem_go = (type_ff == REQ_REMOVE) && found_match_ff;

   always_comb begin
      ok_in     = 1'b0;
      we_in     = 1'b0;
      wme_in    = 1'b0;
      tslot_idx = '0;
      comp_in   = '0;
      mask_in   = '0;
      func_in   = '0;
      hkind_in  = KIND_ACCESS;
      haddr_in  = '0;
      clr_in    = 1'b0;
      case (type_ff)
         REQ_INSERT: begin
            if (found_match_ff) begin
               ok_in = 1'b1;
            end else if (ins_go) begin
               ok_in     = 1'b1;
               we_in     = 1'b1;
               tslot_idx = free_idx_ff;
               func_in   = func_sel;
               // align down when the length is a power of two of two or more
               if (len_pow2 && (len_ff >= 32'd2)) comp_in = addr_ff & ~len_dec;
               else comp_in = addr_ff;
               if (!is_v2) begin
                  wme_in  = 1'b1;
                  mask_in = log2_onehot(len_ff);
               end
            end
         end
         REQ_REMOVE: begin
            ok_in = 1'b1;
            if (found_match_ff) begin
               we_in     = 1'b1;
               wme_in    = 1'b1;
               tslot_idx = match_idx_ff;
            end
         end
         REQ_HIT: begin
            if (!status.n_zero && trap_ff) begin
               clr_in = 1'b1;
               if (found_hit_ff) begin
                  ok_in    = 1'b1;
                  hkind_in = hit_kind_ff;
                  haddr_in = hit_addr_ff;
               end
            end
         end
         default: ok_in = 1'b0;
      endcase
   end

   assign tslot_wide = 32'(tslot_idx);
   assign tslot_in   = tslot_wide[1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= cmd.finish;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         ok_ff    <= ok_in;
         we_ff    <= we_in;
         wme_ff   <= wme_in;
         tslot_ff <= tslot_in;
         comp_ff  <= comp_in;
         mask_ff  <= mask_in;
         func_ff  <= func_in;
         hkind_ff <= hkind_in;
         haddr_ff <= haddr_in;
         clr_ff   <= clr_in;
      end
   end

   // table update; contents of free slots are never looked at
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_SLOTS; i++) used_ff[i] <= 1'b0;
      end else if (cmd.finish) begin
         if (ins_go) used_ff[free_idx_ff] <= 1'b1;
         else if (rem_go) used_ff[match_idx_ff] <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish && ins_go) begin
         slot_addr_ff[free_idx_ff] <= addr_ff;
         slot_len_ff[free_idx_ff]  <= len_ff;
         slot_kind_ff[free_idx_ff] <= kind_ff;
      end
   end

   assign rsp_strobe            = strobe_ff;
   assign rsp_ok                = ok_ff;
   assign rsp_write_enable      = we_ff;
   assign rsp_write_mask_enable = wme_ff;
   assign rsp_target_slot       = tslot_ff;
   assign rsp_comparator_word   = comp_ff;
   assign rsp_mask_word         = mask_ff;
   assign rsp_function_word     = func_ff;
   assign rsp_hit_kind          = hkind_ff;
   assign rsp_hit_addr          = haddr_ff;
   assign rsp_clear_trap        = clr_ff;

endmodule

/* hdl/watchpoint_comparator_table.sv */
// A request is taken when start is high and busy is low. The table is scanned
// one slot per cycle over the active slots n (active_slots capped at
// MAX_SLOTS), and skipped when n is zero. The result is registered after the
// finish state and appears on the rsp_ ports with rsp_strobe high for one
// cycle; busy drops in that same cycle, so a new request can already be taken.
// The result cannot be held off by the receiver and must be captured in its
// strobe cycle. Write the csr_ registers only while busy is low.
// ----------------------------------------------------------------------------
// watchpoint_comparator_table
// Data watchpoint comparator slot allocator: insert, remove and hit check
// against a small slot table, with configuration registers.
// ----------------------------------------------------------------------------
module watchpoint_comparator_table import wct_pkg::*; #(
   parameter int MAX_SLOTS = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_type,
   input  logic [1:0]  req_watch_kind,
   input  logic [31:0] req_watch_addr,
   input  logic [31:0] req_watch_len,
   input  logic        req_trap_flag,
   input  logic [3:0]  req_matched_bits,
   output logic        rsp_strobe,
   output logic        rsp_ok,
   output logic        rsp_write_enable,
   output logic        rsp_write_mask_enable,
   output logic [1:0]  rsp_target_slot,
   output logic [31:0] rsp_comparator_word,
   output logic [4:0]  rsp_mask_word,
   output logic [31:0] rsp_function_word,
   output logic [1:0]  rsp_hit_kind,
   output logic [31:0] rsp_hit_addr,
   output logic        rsp_clear_trap,
   input  logic        csr_write_enable,
   input  logic [1:0]  csr_index,
   input  logic [2:0]  csr_write_data
);

   logic [2:0]    active_ff;
   logic [1:0]    profile_ff;
   logic [2:0]    n_slots;
   dp_cmd_type    cmd;
   dp_status_type status;

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff  <= 3'd4;
         profile_ff <= 2'd1;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_ACTIVE_SLOTS: active_ff  <= csr_write_data;
            CSR_CORE_PROFILE: profile_ff <= csr_write_data[1:0];
            default: ;
         endcase
      end
   end

   assign n_slots = (32'(active_ff) > MAX_SLOTS) ? 3'(MAX_SLOTS) : active_ff;

   wct_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .status (status),
      .cmd    (cmd),
      .busy   (busy)
   );

   wct_datapath #(
      .MAX_SLOTS (MAX_SLOTS)
   ) u_datapath (
      .clock                 (clock),
      .reset                 (reset),
      .cmd                   (cmd),
      .status                (status),
      .n_slots               (n_slots),
      .profile               (profile_ff),
      .req_type              (req_type),
      .req_watch_kind        (req_watch_kind),
      .req_watch_addr        (req_watch_addr),
      .req_watch_len         (req_watch_len),
      .req_trap_flag         (req_trap_flag),
      .req_matched_bits      (req_matched_bits),
      .rsp_strobe            (rsp_strobe),
      .rsp_ok                (rsp_ok),
      .rsp_write_enable      (rsp_write_enable),
      .rsp_write_mask_enable (rsp_write_mask_enable),
      .rsp_target_slot       (rsp_target_slot),
      .rsp_comparator_word   (rsp_comparator_word),
      .rsp_mask_word         (rsp_mask_word),
      .rsp_function_word     (rsp_function_word),
      .rsp_hit_kind          (rsp_hit_kind),
      .rsp_hit_addr          (rsp_hit_addr),
      .rsp_clear_trap        (rsp_clear_trap)
   );

endmodule
